// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/mtsp_pkg.sv =====
// types, constants and tables of the motion to synth parameter mapper
package mtsp_pkg;

    // sample and parameter transfer payloads
    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] yaw_angle;
    } t_motion_in;

    localparam int PARAM_INDEX_W = 4;
    localparam int PARAM_VALUE_W = 24;

    typedef struct packed {
        logic [PARAM_INDEX_W-1:0] param_index;
        logic [PARAM_VALUE_W-1:0] param_value;
        logic                     last_param;
    } t_param_out;

    // square root datapath: 52 bit radicand, two result bits per stage
    localparam int SQ_W             = 52;
    localparam int SQ_ROOT_W        = SQ_W / 2;
    localparam int SQ_REM_W         = SQ_ROOT_W + 2;
    localparam int SQ_BITS_PER_STG  = 2;
    localparam int SQ_STAGES        = SQ_ROOT_W / SQ_BITS_PER_STG;
    localparam int GYRO_SHIFT       = 18;
    localparam int ACCEL_SHIFT      = 6;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_W-1:0]      rad;
    } t_sq_state;

    // parameter slots in emission order
    localparam int NUM_FIXED        = 8;
    localparam int NUM_PARTIALS_DEF = 6;
    localparam int IDX_ROOT         = 0;
    localparam int IDX_DEPTH        = 1;
    localparam int IDX_RATE         = 2;
    localparam int IDX_PAN          = 3;
    localparam int IDX_GAIN         = 4;
    localparam int IDX_NOISE        = 5;
    localparam int IDX_COEF         = 6;
    localparam int IDX_DRIVE        = 7;

    // angle normalization
    localparam int ANGLE_GAIN       = 100;
    localparam int PITCH_OFS        = 643072;
    localparam int PITCH_DEN        = 1286144;
    localparam int WIDE_OFS         = 1286144;
    localparam int WIDE_DEN         = 2572288;

    // scale step
    localparam int STEP_SIZE        = 204800;
    localparam int STEP_MAX         = 10;

    // rounding offsets and divisors, reduced by common powers of two
    localparam int ENERGY_AM_GAIN   = 5;
    localparam int ENERGY_RND       = 50;
    localparam int ENERGY_DIV       = 100;
    localparam int ENERGY_MAX       = 4096;
    localparam int DEPTH_RND        = 6280;
    localparam int DEPTH_DIV        = 12560;
    localparam int RATE_BASE        = 16384;
    localparam int RATE_RND         = 5;
    localparam int RATE_DIV         = 10;
    localparam int PAN_RND          = 314;
    localparam int PAN_DIV          = 628;
    localparam int COEF_GAIN        = 5;
    localparam int COEF_RND         = 1289284;
    localparam int COEF_DIV         = 6280;
    localparam int GAIN_RND         = 2053;
    localparam int GAIN_DIV         = 10;
    localparam int NOISE_RND        = 50;
    localparam int NOISE_DIV        = 100;

    // pentatonic root frequencies over two octaves from C3, Q10.12 Hz
    localparam logic [21:0] ROOT_HZ [0:STEP_MAX] = '{
        22'd535798,  22'd637175,  22'd715204,  22'd802790,
        22'd954683,  22'd1071596, 22'd1274349, 22'd1430408,
        22'd1605579, 22'd1909366, 22'd2143191
    };

endpackage

// ===== design/motion_to_synth_param_map_unit.sv =====
// motion to synth parameter mapper: pipelined datapath and parameter serializer
//
// Usage: one motion sample (gyro, accel, pitch, roll, yaw) is a transfer on
// i_valid/o_ready with payload i_motion. For each sample the block sends
// 8 + NUM_PARTIALS parameter values on o_valid/i_ready with payload o_param,
// in index order, last_param set on the final one.
// The datapath is 19 register stages deep (squares, sums, 13 stages
// of a two-bit-per-stage square root, four stages of reciprocal divides and
// scaling), followed by the output bank.
// Throughput: the output bank sends one value per cycle while i_ready is high,
// so a sample takes 8 + NUM_PARTIALS transfers (14 by default); the serializer sets the rate.
// Up to 19 samples may sit in the datapath behind a busy output bank.
// The next burst loads into the bank in the cycle its last value leaves, so
// bursts follow back to back.
// Stall: when i_ready is low the bank holds its value; when the last
// datapath stage is full and cannot load, the whole datapath holds and
// o_ready drops. Nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the datapath and the output bank.
`include "assert_macros.svh"

module motion_to_synth_param_map_unit #(
    parameter int NUM_PARTIALS = mtsp_pkg::NUM_PARTIALS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  mtsp_pkg::t_motion_in  i_motion,
    output logic                  o_valid,
    input  logic                  i_ready,
    output mtsp_pkg::t_param_out  o_param
);

    localparam int NUM_VALS = mtsp_pkg::NUM_FIXED + NUM_PARTIALS;
    localparam int CNT_W    = $clog2(NUM_VALS);
    localparam int VW       = mtsp_pkg::PARAM_VALUE_W;
    localparam int NSQ      = mtsp_pkg::SQ_STAGES;

    // reciprocal constants: q = (x * M) >> K, exact for every x below 2^W
    localparam int EN_W = 24;
    localparam int EN_K = EN_W + $clog2(mtsp_pkg::ENERGY_DIV);
    localparam logic [EN_W:0] EN_M =
        (EN_W+1)'(((64'd1 << EN_K) / mtsp_pkg::ENERGY_DIV) + 64'd1);
    localparam int DP_W = 21;
    localparam int DP_K = DP_W + $clog2(mtsp_pkg::DEPTH_DIV);
    localparam logic [DP_W:0] DP_M =
        (DP_W+1)'(((64'd1 << DP_K) / mtsp_pkg::DEPTH_DIV) + 64'd1);
    localparam int RT_W = 18;
    localparam int RT_K = RT_W + $clog2(mtsp_pkg::RATE_DIV);
    localparam logic [RT_W:0] RT_M =
        (RT_W+1)'(((64'd1 << RT_K) / mtsp_pkg::RATE_DIV) + 64'd1);
    localparam int PN_W = 22;
    localparam int PN_K = PN_W + $clog2(mtsp_pkg::PAN_DIV);
    localparam logic [PN_W:0] PN_M =
        (PN_W+1)'(((64'd1 << PN_K) / mtsp_pkg::PAN_DIV) + 64'd1);
    localparam int CF_W = 24;
    localparam int CF_K = CF_W + $clog2(mtsp_pkg::COEF_DIV);
    localparam logic [CF_W:0] CF_M =
        (CF_W+1)'(((64'd1 << CF_K) / mtsp_pkg::COEF_DIV) + 64'd1);
    localparam int GN_W = 16;
    localparam int GN_K = GN_W + $clog2(mtsp_pkg::GAIN_DIV);
    localparam logic [GN_W:0] GN_M =
        (GN_W+1)'(((64'd1 << GN_K) / mtsp_pkg::GAIN_DIV) + 64'd1);
    localparam int NZ_W = 16;
    localparam int NZ_K = NZ_W + $clog2(mtsp_pkg::NOISE_DIV);
    localparam logic [NZ_W:0] NZ_M =
        (NZ_W+1)'(((64'd1 << NZ_K) / mtsp_pkg::NOISE_DIV) + 64'd1);

    // one square root stage: SQ_BITS_PER_STG restoring digit steps
    function automatic mtsp_pkg::t_sq_state sq_step(input mtsp_pkg::t_sq_state s);
        mtsp_pkg::t_sq_state         r;
        logic [mtsp_pkg::SQ_REM_W-1:0] rem_sh;
        logic [mtsp_pkg::SQ_REM_W-1:0] trial;
        r = s;
        for (int i = 0; i < mtsp_pkg::SQ_BITS_PER_STG; i++) begin
            rem_sh = {r.rem[mtsp_pkg::SQ_REM_W-3:0], r.rad[mtsp_pkg::SQ_W-1 -: 2]};
            trial  = {r.root, 2'b01};
            if (rem_sh >= trial) begin
                r.rem  = rem_sh - trial;
                r.root = {r.root[mtsp_pkg::SQ_ROOT_W-2:0], 1'b1};
            end else begin
                r.rem  = rem_sh;
                r.root = {r.root[mtsp_pkg::SQ_ROOT_W-2:0], 1'b0};
            end
            r.rad = {r.rad[mtsp_pkg::SQ_W-3:0], 2'b00};
        end
        return r;
    endfunction

    logic adv;
    logic load;
    logic last_xfer;

    // ---------------- stage 1: squares and angle gains ----------------
    logic               r_s1_vld;
    logic [30:0]        r_s1_sq  [6];
    logic signed [23:0] r_s1_ang [3];
    logic signed [15:0] vec_c    [6];
    logic signed [15:0] ang_c    [3];

    always_comb begin
        vec_c[0] = i_motion.gyro_x;
        vec_c[1] = i_motion.gyro_y;
        vec_c[2] = i_motion.gyro_z;
        vec_c[3] = i_motion.accel_x;
        vec_c[4] = i_motion.accel_y;
        vec_c[5] = i_motion.accel_z;
        ang_c[0] = i_motion.pitch_angle;
        ang_c[1] = i_motion.roll_angle;
        ang_c[2] = i_motion.yaw_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 6; j++) begin
                r_s1_sq[j] <= 31'(32'(vec_c[j]) * 32'(vec_c[j]));
            end
            for (int j = 0; j < 3; j++) begin
                r_s1_ang[j] <= 24'(ang_c[j]) * 24'(mtsp_pkg::ANGLE_GAIN);
            end
        end
    end

    // ---------------- stage 2: sums and normalized angles ----------------
    logic                         r_sq_vld [0:NSQ];
    mtsp_pkg::t_sq_state          r_sqg    [0:NSQ];
    mtsp_pkg::t_sq_state          r_sqa    [0:NSQ];
    logic [20:0]                  r_pn     [0:NSQ];
    logic [21:0]                  r_rn     [0:NSQ];
    logic [21:0]                  r_yn     [0:NSQ];
    logic [31:0]                  g_sum_c;
    logic [31:0]                  a_sum_c;
    logic signed [24:0]           pn_c;
    logic signed [24:0]           rn_c;
    logic signed [24:0]           yn_c;
    logic [20:0]                  n_pn;
    logic [21:0]                  n_rn;
    logic [21:0]                  n_yn;

    always_comb begin
        g_sum_c = 32'(r_s1_sq[0]) + 32'(r_s1_sq[1]) + 32'(r_s1_sq[2]);
        a_sum_c = 32'(r_s1_sq[3]) + 32'(r_s1_sq[4]) + 32'(r_s1_sq[5]);
        pn_c = 25'(r_s1_ang[0]) + 25'(mtsp_pkg::PITCH_OFS);
        rn_c = 25'(r_s1_ang[1]) + 25'(mtsp_pkg::WIDE_OFS);
        yn_c = 25'(r_s1_ang[2]) + 25'(mtsp_pkg::WIDE_OFS);
        // clamp to the normalized range
        if (pn_c < 0)                                 n_pn = '0;
        else if (pn_c > 25'(mtsp_pkg::PITCH_DEN))     n_pn = 21'(mtsp_pkg::PITCH_DEN);
        else                                          n_pn = 21'(pn_c);
        if (rn_c < 0)                                 n_rn = '0;
        else if (rn_c > 25'(mtsp_pkg::WIDE_DEN))      n_rn = 22'(mtsp_pkg::WIDE_DEN);
        else                                          n_rn = 22'(rn_c);
        if (yn_c < 0)                                 n_yn = '0;
        else if (yn_c > 25'(mtsp_pkg::WIDE_DEN))      n_yn = 22'(mtsp_pkg::WIDE_DEN);
        else                                          n_yn = 22'(yn_c);
    end

    // ---------------- square root stages ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NSQ; k++) begin
                r_sq_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_sq_vld[0] <= r_s1_vld;
            for (int k = 1; k <= NSQ; k++) begin
                r_sq_vld[k] <= r_sq_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqg[0].rem  <= '0;
            r_sqg[0].root <= '0;
            r_sqg[0].rad  <= mtsp_pkg::SQ_W'({g_sum_c, mtsp_pkg::GYRO_SHIFT'(0)});
            r_sqa[0].rem  <= '0;
            r_sqa[0].root <= '0;
            r_sqa[0].rad  <= mtsp_pkg::SQ_W'({a_sum_c, mtsp_pkg::ACCEL_SHIFT'(0)});
            r_pn[0]       <= n_pn;
            r_rn[0]       <= n_rn;
            r_yn[0]       <= n_yn;
            for (int k = 1; k <= NSQ; k++) begin
                r_sqg[k] <= sq_step(r_sqg[k-1]);
                r_sqa[k] <= sq_step(r_sqa[k-1]);
                r_pn[k]  <= r_pn[k-1];
                r_rn[k]  <= r_rn[k-1];
                r_yn[k]  <= r_yn[k-1];
            end
        end
    end

    // ---------------- P0: magnitudes, numerators, scale step ----------------
    logic        r_p0_vld;
    logic [23:0] r_p0_xe;
    logic [3:0]  r_p0_step;
    logic [20:0] r_p0_n1;
    logic [17:0] r_p0_n2;
    logic [21:0] r_p0_n3;
    logic [23:0] r_p0_n6;
    logic [21:0] r_p0_np [NUM_PARTIALS];
    logic [24:0] gm_sum_c;
    logic [18:0] am_sum_c;
    logic [23:0] gm_c;
    logic [17:0] am_c;
    logic [3:0]  step_c;
    logic [31:0] rn_scaled_c;
    logic signed [31:0] t_c;
    logic [21:0] f_c [NUM_PARTIALS];

    always_comb begin
        // round half up: (isqrt(4y) + 1) >> 1
        gm_sum_c = 25'(r_sqg[NSQ].root) + 25'd1;
        am_sum_c = 19'(r_sqa[NSQ].root) + 19'd1;
        gm_c     = gm_sum_c[24:1];
        am_c     = am_sum_c[18:1];
        step_c   = '0;
        for (int k = 1; k <= mtsp_pkg::STEP_MAX; k++) begin
            if (gm_c >= 24'(k * mtsp_pkg::STEP_SIZE)) step_c = 4'(k);
        end
        // partial fade amount from the roll cutoff
        rn_scaled_c = 32'(r_rn[NSQ]) * 32'(NUM_PARTIALS - 1);
        t_c = '0;
        for (int p = 0; p < NUM_PARTIALS; p++) begin
            t_c = signed'(rn_scaled_c) + 32'((1 - p) * mtsp_pkg::WIDE_DEN);
            if (t_c < 0)                                f_c[p] = '0;
            else if (t_c > 32'(mtsp_pkg::WIDE_DEN))     f_c[p] = 22'(mtsp_pkg::WIDE_DEN);
            else                                        f_c[p] = 22'(t_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
        end else if (adv) begin
            r_p0_vld <= r_sq_vld[NSQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p0_xe   <= gm_c + 24'(am_c) * 24'(mtsp_pkg::ENERGY_AM_GAIN)
                         + 24'(mtsp_pkg::ENERGY_RND);
            r_p0_step <= step_c;
            r_p0_n1   <= r_pn[NSQ] + 21'(mtsp_pkg::DEPTH_RND);
            r_p0_n2   <= am_c + 18'(mtsp_pkg::RATE_RND);
            r_p0_n3   <= r_yn[NSQ] + 22'(mtsp_pkg::PAN_RND);
            r_p0_n6   <= 24'(r_rn[NSQ]) * 24'(mtsp_pkg::COEF_GAIN)
                         + 24'(mtsp_pkg::COEF_RND);
            for (int p = 0; p < NUM_PARTIALS; p++) begin
                r_p0_np[p] <= f_c[p] + 22'((p + 1) * mtsp_pkg::PAN_RND);
            end
        end
    end

    // ---------------- P1: reciprocal divides and root lookup ----------------
    logic        r_p1_vld;
    logic [17:0] r_p1_qe;
    logic [21:0] r_p1_root;
    logic [6:0]  r_p1_q1;
    logic [15:0] r_p1_rate;
    logic [12:0] r_p1_q3;
    logic [11:0] r_p1_q6;
    logic [12:0] r_p1_qp [NUM_PARTIALS];
    logic [2*EN_W:0] prod_en_c;
    logic [2*DP_W:0] prod_dp_c;
    logic [2*RT_W:0] prod_rt_c;
    logic [2*PN_W:0] prod_pn_c;
    logic [2*CF_W:0] prod_cf_c;
    logic [12:0]     qp_c [NUM_PARTIALS];

    always_comb begin
        prod_en_c = (2*EN_W+1)'(r_p0_xe) * (2*EN_W+1)'(EN_M);
        prod_dp_c = (2*DP_W+1)'(r_p0_n1) * (2*DP_W+1)'(DP_M);
        prod_rt_c = (2*RT_W+1)'(r_p0_n2) * (2*RT_W+1)'(RT_M);
        prod_pn_c = (2*PN_W+1)'(r_p0_n3) * (2*PN_W+1)'(PN_M);
        prod_cf_c = (2*CF_W+1)'(r_p0_n6) * (2*CF_W+1)'(CF_M);
    end

    // partial p divides by 628 * (p + 1)
    for (genvar gp = 0; gp < NUM_PARTIALS; gp++) begin : g_part
        localparam int PD   = mtsp_pkg::PAN_DIV * (gp + 1);
        localparam int PK   = PN_W + $clog2(PD);
        localparam logic [PN_W:0] PM = (PN_W+1)'(((64'd1 << PK) / PD) + 64'd1);
        logic [2*PN_W:0] prod_c;
        assign prod_c    = (2*PN_W+1)'(r_p0_np[gp]) * (2*PN_W+1)'(PM);
        assign qp_c[gp]  = 13'(prod_c >> PK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (adv) begin
            r_p1_vld <= r_p0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_qe   <= 18'(prod_en_c >> EN_K);
            r_p1_root <= mtsp_pkg::ROOT_HZ[r_p0_step];
            r_p1_q1   <= 7'(prod_dp_c >> DP_K);
            r_p1_rate <= 16'(prod_rt_c >> RT_K) + 16'(mtsp_pkg::RATE_BASE);
            r_p1_q3   <= 13'(prod_pn_c >> PN_K);
            r_p1_q6   <= 12'(prod_cf_c >> CF_K);
            for (int p = 0; p < NUM_PARTIALS; p++) begin
                r_p1_qp[p] <= qp_c[p];
            end
        end
    end

    // ---------------- P2: energy clamp and energy terms ----------------
    logic          r_p2_vld;
    logic [VW-1:0] r_p2_vals [NUM_VALS];
    logic [12:0]   e_c;
    logic [13:0]   drive_c;
    logic [VW-1:0] n_p2_vals [NUM_VALS];

    always_comb begin
        e_c = (r_p1_qe > 18'(mtsp_pkg::ENERGY_MAX)) ? 13'(mtsp_pkg::ENERGY_MAX)
                                                     : 13'(r_p1_qe);
        drive_c = 14'(e_c) * 14'd3 + 14'd1;
        n_p2_vals[mtsp_pkg::IDX_ROOT]  = VW'(r_p1_root);
        n_p2_vals[mtsp_pkg::IDX_DEPTH] = VW'(r_p1_q1);
        n_p2_vals[mtsp_pkg::IDX_RATE]  = VW'(r_p1_rate);
        n_p2_vals[mtsp_pkg::IDX_PAN]   = VW'(r_p1_q3);
        // gain and noise carry their numerators into the next stage
        n_p2_vals[mtsp_pkg::IDX_GAIN]  = VW'(16'(e_c) * 16'd8 + 16'(mtsp_pkg::GAIN_RND));
        n_p2_vals[mtsp_pkg::IDX_NOISE] = VW'(16'(e_c) * 16'd15 + 16'(mtsp_pkg::NOISE_RND));
        n_p2_vals[mtsp_pkg::IDX_COEF]  = VW'(r_p1_q6);
        n_p2_vals[mtsp_pkg::IDX_DRIVE] = VW'(drive_c[13:1]);
        for (int p = 0; p < NUM_PARTIALS; p++) begin
            n_p2_vals[mtsp_pkg::NUM_FIXED + p] = VW'(r_p1_qp[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (adv) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_vals <= n_p2_vals;
        end
    end

    // ---------------- P3: gain and noise divides ----------------
    logic          r_p3_vld;
    logic [VW-1:0] r_p3_vals [NUM_VALS];
    logic [2*GN_W:0] prod_gn_c;
    logic [2*NZ_W:0] prod_nz_c;
    logic [VW-1:0]   n_p3_vals [NUM_VALS];

    always_comb begin
        prod_gn_c = (2*GN_W+1)'(GN_W'(r_p2_vals[mtsp_pkg::IDX_GAIN])) * (2*GN_W+1)'(GN_M);
        prod_nz_c = (2*NZ_W+1)'(NZ_W'(r_p2_vals[mtsp_pkg::IDX_NOISE])) * (2*NZ_W+1)'(NZ_M);
        n_p3_vals = r_p2_vals;
        n_p3_vals[mtsp_pkg::IDX_GAIN]  = VW'(prod_gn_c >> GN_K);
        n_p3_vals[mtsp_pkg::IDX_NOISE] = VW'(prod_nz_c >> NZ_K);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else if (adv) begin
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_vals <= n_p3_vals;
        end
    end

    // ---------------- output bank: one value per transfer ----------------
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_bank [NUM_VALS];

    assign last_xfer = r_busy && i_ready && (r_cnt == CNT_W'(NUM_VALS - 1));
    assign load      = r_p3_vld && (!r_busy || last_xfer);
    assign adv       = !r_p3_vld || load;
    assign o_ready   = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy && i_ready) begin
            r_busy <= !last_xfer;
            r_cnt  <= last_xfer ? '0 : r_cnt + CNT_W'(1);
        end
    end

    // shift the bank so the current value always sits in slot zero
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bank <= r_p3_vals;
        end else if (r_busy && i_ready) begin
            for (int k = 0; k < NUM_VALS - 1; k++) begin
                r_bank[k] <= r_bank[k+1];
            end
        end
    end

    assign o_valid             = r_busy;
    assign o_param.param_index = mtsp_pkg::PARAM_INDEX_W'(r_cnt);
    assign o_param.param_value = r_bank[0];
    assign o_param.last_param  = (r_cnt == CNT_W'(NUM_VALS - 1));

    // ---------------- assertions ----------------
    `ASSERT_PROP(a_load_starts_burst, i_clk, i_rst_n, load |=> (r_busy && r_cnt == '0), "bank load did not restart the burst")
    `ASSERT_PROP(a_busy_ends_on_last, i_clk, i_rst_n, $fell(r_busy) |-> $past(last_xfer), "burst ended before its last value")
    `ASSERT_PROP(a_stall_holds_pipe, i_clk, i_rst_n, (r_p3_vld && !adv) |=> (r_p3_vld && $stable(r_p3_vals[0])), "datapath moved during a stall")
    `ASSERT_NEVER(a_step_range, i_clk, i_rst_n, r_p0_vld && (r_p0_step > 4'(mtsp_pkg::STEP_MAX)), "scale step beyond table")

endmodule
